// File: sv/hett_pkg.sv
// shared types, constants and the arctangent table for the heading error block
package hett_pkg;

    localparam int COORD_WIDTH   = 16;
    localparam int DIFF_WIDTH    = COORD_WIDTH + 1;
    localparam int PRESCALE      = 24;
    localparam int CORDIC_STEPS  = 16;
    localparam int CORDIC_WIDTH  = DIFF_WIDTH + PRESCALE + 3;
    localparam int Z_WIDTH       = 32;
    localparam int ANG_FRAC      = 16;
    localparam int ANG_WIDTH     = Z_WIDTH - ANG_FRAC;
    localparam int TURN_WIDTH    = 15;
    localparam int TOL_WIDTH     = 15;
    localparam int DB_WIDTH      = 14;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_AW       = $clog2(FIFO_DEPTH);
    localparam int LANE_LATENCY  = CORDIC_STEPS + 2;
    localparam int ATAN_LEN      = 24;
    localparam int APB_AW        = 3;
    localparam int APB_DW        = 32;

    localparam logic signed [ANG_WIDTH-1:0] DEG180   = ANG_WIDTH'(11520);
    localparam logic signed [ANG_WIDTH-1:0] DEG90    = ANG_WIDTH'(5760);
    localparam logic signed [Z_WIDTH-1:0]   Z_DEG180 = Z_WIDTH'(754974720);

    // atan(2^-i) in units of 2^-22 degree, rounded to nearest
    localparam logic signed [Z_WIDTH-1:0] ATAN_TAB [ATAN_LEN] = '{
        Z_WIDTH'(188743680), Z_WIDTH'(111421900), Z_WIDTH'(58872272),
        Z_WIDTH'(29884485),  Z_WIDTH'(15000234),  Z_WIDTH'(7507429),
        Z_WIDTH'(3754631),   Z_WIDTH'(1877430),   Z_WIDTH'(938729),
        Z_WIDTH'(469366),    Z_WIDTH'(234683),    Z_WIDTH'(117342),
        Z_WIDTH'(58671),     Z_WIDTH'(29335),     Z_WIDTH'(14668),
        Z_WIDTH'(7334),      Z_WIDTH'(3667),      Z_WIDTH'(1833),
        Z_WIDTH'(917),       Z_WIDTH'(458),       Z_WIDTH'(229),
        Z_WIDTH'(115),       Z_WIDTH'(57),        Z_WIDTH'(29)
    };

    localparam logic [1:0] DIR_STRAIGHT = 2'd0;
    localparam logic [1:0] DIR_LEFT     = 2'd1;
    localparam logic [1:0] DIR_RIGHT    = 2'd2;

    localparam logic REG_TOLERANCE = 1'b0;
    localparam logic REG_DEADBAND  = 1'b1;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] prev_x;
        logic signed [COORD_WIDTH-1:0] prev_y;
        logic signed [COORD_WIDTH-1:0] cur_x;
        logic signed [COORD_WIDTH-1:0] cur_y;
        logic signed [COORD_WIDTH-1:0] target_x;
        logic signed [COORD_WIDTH-1:0] target_y;
    } in_item_t;

    typedef struct packed {
        logic signed [TURN_WIDTH-1:0] turn_angle;
        logic [1:0]                   turn_dir;
        logic                         stationary;
    } out_item_t;

    // one angle to find: either an axis-snapped constant or a cordic job
    typedef struct packed {
        logic                         snap;
        logic signed [ANG_WIDTH-1:0]  snap_angle;
        logic signed [DIFF_WIDTH-1:0] x0;
        logic signed [DIFF_WIDTH-1:0] y0;
        logic signed [Z_WIDTH-1:0]    z0;
    } lane_cls_t;

    typedef struct packed {
        logic      stationary;
        lane_cls_t hdg;
        lane_cls_t brg;
    } cls_t;

endpackage

// File: sv/heading_error_to_target.sv
// top level: configuration registers, front classifier, queue and cordic back end
//
// Input channel s_valid/s_ready/s_item carries our previous and current position
// and the target position; output channel m_valid/m_ready/m_item returns one item
// per input: turn angle (bearing minus heading, 1/64 degree, wrapped to +-180),
// turn direction against the deadband, and the stationary flag.
// Registers on the APB port: tolerance at 0x0, deadband at 0x4; write them only
// while no item is in flight.
// Throughput is one item per cycle while m_ready does not hold the back pipeline:
// heading and bearing each run in a 16-stage cordic pipeline, one iteration per
// stage, so a new item can enter every cycle.
// From input accept to m_valid an item passes the front register, the queue, the
// scaling stage, 16 iterations, rounding, difference and wrap, and the output register.
// When m_ready is low while m_valid is high the whole back pipeline holds; the four-entry
// queue and the front register keep taking items until they fill, then s_ready drops.
// Synchronous reset clears both registers to zero and empties the pipeline.
module heading_error_to_target (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  hett_pkg::in_item_t             s_item,
    output logic                           m_valid,
    input  logic                           m_ready,
    output hett_pkg::out_item_t            m_item,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hett_pkg::APB_AW-1:0]    paddr,
    input  logic [hett_pkg::APB_DW-1:0]    pwdata,
    output logic [hett_pkg::APB_DW-1:0]    prdata,
    output logic                           pready
);
    import hett_pkg::*;

    logic [TOL_WIDTH-1:0] tolerance_reg;
    logic [DB_WIDTH-1:0]  deadband_reg;
    logic                 reg_sel;
    logic                 front_valid;
    logic                 front_ready;
    cls_t                 front_cls;
    logic                 back_valid;
    logic                 back_ready;
    cls_t                 back_cls;

    assign pready  = 1'b1;
    assign reg_sel = paddr[APB_AW-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tolerance_reg <= '0;
            deadband_reg  <= '0;
        end else if (psel && penable && pwrite) begin
            case (reg_sel)
                REG_TOLERANCE: tolerance_reg <= pwdata[TOL_WIDTH-1:0];
                REG_DEADBAND:  deadband_reg  <= pwdata[DB_WIDTH-1:0];
                default:       tolerance_reg <= tolerance_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_TOLERANCE: prdata = APB_DW'(tolerance_reg);
            REG_DEADBAND:  prdata = APB_DW'(deadband_reg);
            default:       prdata = '0;
        endcase
    end

    hett_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .tolerance (tolerance_reg),
        .cls_valid (front_valid),
        .cls_ready (front_ready),
        .cls       (front_cls)
    );

    hett_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_cls),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_data   (back_cls)
    );

    hett_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cls_valid (back_valid),
        .cls_ready (back_ready),
        .cls       (back_cls),
        .deadband  (deadband_reg),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule

// File: sv/hett_cordic.sv
// pipelined vectoring cordic, one iteration per stage, angle rounded to 1/64 degree
module hett_cordic (
    input  logic                                  aclk,
    input  logic                                  en,
    input  logic signed [hett_pkg::DIFF_WIDTH-1:0] x0,
    input  logic signed [hett_pkg::DIFF_WIDTH-1:0] y0,
    input  logic signed [hett_pkg::Z_WIDTH-1:0]    z0,
    output logic signed [hett_pkg::ANG_WIDTH-1:0]  angle
);
    import hett_pkg::*;

    localparam logic signed [Z_WIDTH-1:0] HALF_UP = Z_WIDTH'(1) <<< (ANG_FRAC - 1);
    localparam logic signed [Z_WIDTH-1:0] HALF_DN = HALF_UP - Z_WIDTH'(1);

    logic signed [CORDIC_WIDTH-1:0] x_reg [CORDIC_STEPS+1];
    logic signed [CORDIC_WIDTH-1:0] y_reg [CORDIC_STEPS+1];
    logic signed [Z_WIDTH-1:0]      z_reg [CORDIC_STEPS+1];
    logic signed [ANG_WIDTH-1:0]    angle_reg;
    logic signed [Z_WIDTH-1:0]      zf;
    logic signed [Z_WIDTH-1:0]      rsum;
    logic signed [ANG_WIDTH-1:0]    rnd;

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0] <= CORDIC_WIDTH'(x0) <<< PRESCALE;
            y_reg[0] <= CORDIC_WIDTH'(y0) <<< PRESCALE;
            z_reg[0] <= z0;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
        logic signed [CORDIC_WIDTH-1:0] xs;
        logic signed [CORDIC_WIDTH-1:0] ys;
        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;

        always_ff @(posedge aclk) begin
            if (en) begin
                if (y_reg[i] > 0) begin
                    x_reg[i+1] <= x_reg[i] + ys;
                    y_reg[i+1] <= y_reg[i] - xs;
                    z_reg[i+1] <= z_reg[i] + ATAN_TAB[i];
                end else begin
                    x_reg[i+1] <= x_reg[i] - ys;
                    y_reg[i+1] <= y_reg[i] + xs;
                    z_reg[i+1] <= z_reg[i] - ATAN_TAB[i];
                end
            end
        end
    end

    // half away from zero: negative side rounds with one less than half
    assign zf   = z_reg[CORDIC_STEPS];
    assign rsum = zf + ((zf >= 0) ? HALF_UP : HALF_DN);
    assign rnd  = ANG_WIDTH'(rsum >>> ANG_FRAC);

    always_ff @(posedge aclk) begin
        if (en) begin
            if (rnd > DEG180) begin
                angle_reg <= DEG180;
            end else if (rnd < -DEG180) begin
                angle_reg <= -DEG180;
            end else begin
                angle_reg <= rnd;
            end
        end
    end

    assign angle = angle_reg;

endmodule

// File: sv/hett_fifo.sv
// short queue of classified items between the front and back parts
module hett_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  hett_pkg::cls_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output hett_pkg::cls_t pop_data
);
    import hett_pkg::*;

    cls_t               mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg;
    logic               push;
    logic               pop;

    assign push_ready = count_reg != (FIFO_AW+1)'(FIFO_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + (FIFO_AW+1)'(1);
                2'b01:   count_reg <= count_reg - (FIFO_AW+1)'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// File: sv/hett_front.sv
// front part: takes an item, forms the differences and classifies both angles
module hett_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  hett_pkg::in_item_t               s_item,
    input  logic [hett_pkg::TOL_WIDTH-1:0]   tolerance,
    output logic                             cls_valid,
    input  logic                             cls_ready,
    output hett_pkg::cls_t                   cls
);
    import hett_pkg::*;

    function automatic logic in_tol(input logic signed [DIFF_WIDTH-1:0] d,
                                    input logic [TOL_WIDTH-1:0] tol);
        logic signed [DIFF_WIDTH:0] dw;
        logic signed [DIFF_WIDTH:0] tw;
        dw = (DIFF_WIDTH+1)'(d);
        tw = $signed((DIFF_WIDTH+1)'(tol));
        return (dw >= -tw) && (dw <= tw);
    endfunction

    // angle of (dx, dy) as atan2(dy, -dx), snapped to an axis when close to one
    function automatic lane_cls_t classify(input logic signed [DIFF_WIDTH-1:0] dx,
                                           input logic signed [DIFF_WIDTH-1:0] dy,
                                           input logic [TOL_WIDTH-1:0] tol);
        lane_cls_t c;
        logic      dy_in;
        logic      dx_in;
        dy_in = in_tol(dy, tol);
        dx_in = in_tol(dx, tol);
        c.snap = dy_in || dx_in;
        if (dy_in) begin
            c.snap_angle = (dx > 0) ? DEG180 : '0;
        end else begin
            c.snap_angle = (dy > 0) ? DEG90 : -DEG90;
        end
        // x operand is -dx; when negative, pre-rotate by half a turn
        if (dx > 0) begin
            c.z0 = (dy >= 0) ? Z_DEG180 : -Z_DEG180;
            c.x0 = dx;
            c.y0 = -dy;
        end else begin
            c.z0 = '0;
            c.x0 = -dx;
            c.y0 = dy;
        end
        return c;
    endfunction

    logic                         valid_reg;
    cls_t                         cls_reg;
    logic signed [DIFF_WIDTH-1:0] mdx;
    logic signed [DIFF_WIDTH-1:0] mdy;
    logic signed [DIFF_WIDTH-1:0] tdx;
    logic signed [DIFF_WIDTH-1:0] tdy;

    assign mdx = DIFF_WIDTH'(s_item.cur_x) - DIFF_WIDTH'(s_item.prev_x);
    assign mdy = DIFF_WIDTH'(s_item.cur_y) - DIFF_WIDTH'(s_item.prev_y);
    assign tdx = DIFF_WIDTH'(s_item.target_x) - DIFF_WIDTH'(s_item.cur_x);
    assign tdy = DIFF_WIDTH'(s_item.target_y) - DIFF_WIDTH'(s_item.cur_y);

    assign s_ready   = !valid_reg || cls_ready;
    assign cls_valid = valid_reg;
    assign cls       = cls_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cls_reg.stationary <= in_tol(mdx, tolerance) && in_tol(mdy, tolerance);
            cls_reg.hdg        <= classify(mdx, mdy, tolerance);
            cls_reg.brg        <= classify(tdx, tdy, tolerance);
        end
    end

endmodule

// File: sv/hett_back.sv
// back part: two cordic lanes, angle difference with wrap, turn decision, output register
module hett_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cls_valid,
    output logic                           cls_ready,
    input  hett_pkg::cls_t                 cls,
    input  logic [hett_pkg::DB_WIDTH-1:0]  deadband,
    output logic                           m_valid,
    input  logic                           m_ready,
    output hett_pkg::out_item_t            m_item
);
    import hett_pkg::*;

    typedef struct packed {
        logic                        stationary;
        logic                        hdg_snap;
        logic signed [ANG_WIDTH-1:0] hdg_angle;
        logic                        brg_snap;
        logic signed [ANG_WIDTH-1:0] brg_angle;
    } side_t;

    logic                         en;
    logic [LANE_LATENCY-1:0]      vld_reg;
    side_t                        side_reg [LANE_LATENCY];
    logic signed [ANG_WIDTH-1:0]  hdg_cordic;
    logic signed [ANG_WIDTH-1:0]  brg_cordic;
    logic signed [ANG_WIDTH-1:0]  hdg;
    logic signed [ANG_WIDTH-1:0]  brg;
    logic signed [ANG_WIDTH:0]    diff;
    logic signed [ANG_WIDTH:0]    wrapped;
    logic                         dvld_reg;
    logic signed [TURN_WIDTH-1:0] diff_reg;
    logic                         stat_reg;
    logic signed [TURN_WIDTH:0]   a_ext;
    logic signed [TURN_WIDTH:0]   db_ext;
    logic                         m_valid_reg;
    out_item_t                    m_item_reg;

    // the whole back pipeline moves together whenever the output can take an item
    assign en        = !m_valid_reg || m_ready;
    assign cls_ready = en;

    hett_cordic u_hdg (
        .aclk  (aclk),
        .en    (en),
        .x0    (cls.hdg.x0),
        .y0    (cls.hdg.y0),
        .z0    (cls.hdg.z0),
        .angle (hdg_cordic)
    );

    hett_cordic u_brg (
        .aclk  (aclk),
        .en    (en),
        .x0    (cls.brg.x0),
        .y0    (cls.brg.y0),
        .z0    (cls.brg.z0),
        .angle (brg_cordic)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0].stationary <= cls.stationary;
            side_reg[0].hdg_snap   <= cls.hdg.snap;
            side_reg[0].hdg_angle  <= cls.hdg.snap_angle;
            side_reg[0].brg_snap   <= cls.brg.snap;
            side_reg[0].brg_angle  <= cls.brg.snap_angle;
            for (int k = 1; k < LANE_LATENCY; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign hdg = side_reg[LANE_LATENCY-1].hdg_snap ? side_reg[LANE_LATENCY-1].hdg_angle
                                                   : hdg_cordic;
    assign brg = side_reg[LANE_LATENCY-1].brg_snap ? side_reg[LANE_LATENCY-1].brg_angle
                                                   : brg_cordic;
    assign diff = (ANG_WIDTH+1)'(brg) - (ANG_WIDTH+1)'(hdg);

    always_comb begin
        if (diff < -(ANG_WIDTH+1)'(DEG180)) begin
            wrapped = diff + ((ANG_WIDTH+1)'(DEG180) <<< 1);
        end else if (diff > (ANG_WIDTH+1)'(DEG180)) begin
            wrapped = diff - ((ANG_WIDTH+1)'(DEG180) <<< 1);
        end else begin
            wrapped = diff;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            stat_reg <= side_reg[LANE_LATENCY-1].stationary;
            diff_reg <= side_reg[LANE_LATENCY-1].stationary ? '0
                                                            : TURN_WIDTH'(wrapped);
        end
    end

    assign a_ext  = (TURN_WIDTH+1)'(diff_reg);
    assign db_ext = $signed((TURN_WIDTH+1)'(deadband));

    always_ff @(posedge aclk) begin
        if (en) begin
            m_item_reg.turn_angle <= diff_reg;
            m_item_reg.stationary <= stat_reg;
            if (a_ext < -db_ext) begin
                m_item_reg.turn_dir <= DIR_LEFT;
            end else if (a_ext > db_ext) begin
                m_item_reg.turn_dir <= DIR_RIGHT;
            end else begin
                m_item_reg.turn_dir <= DIR_STRAIGHT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            dvld_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= {vld_reg[LANE_LATENCY-2:0], cls_valid};
            dvld_reg    <= vld_reg[LANE_LATENCY-1];
            m_valid_reg <= dvld_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule
